[rtl/core/prt_pkg.sv]
// ----------------------------------------------------------------------------
// prt_pkg
// shared constants of the paged radix trie key-value store
// ----------------------------------------------------------------------------
package prt_pkg;

  // default sizing
  localparam int unsigned NodePoolDefault    = 64;
  localparam int unsigned PagePoolDefault    = 1024;
  localparam int unsigned SlotsInPageDefault = 256;
  localparam int unsigned LevelStrideDefault = 16;

  // request kinds carried in tuser
  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  // response status codes
  localparam logic [2:0] StNew     = 3'd0;
  localparam logic [2:0] StUpdated = 3'd1;
  localparam logic [2:0] StFound   = 3'd2;
  localparam logic [2:0] StMiss    = 3'd3;
  localparam logic [2:0] StReject  = 3'd4;
  localparam logic [2:0] StOom     = 3'd5;

  // one slot: key in the low half, value in the high half
  typedef struct packed {
    logic [63:0] val;
    logic [63:0] key;
  } slot_t;

endpackage

[rtl/core/prt_ram.sv]
// ----------------------------------------------------------------------------
// prt_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/paged_radix_trie_key_value_store_unit.sv]
// ----------------------------------------------------------------------------
// paged_radix_trie_key_value_store_unit
// key-value trie over 64-bit keys with paged nodes held in block ram
// ----------------------------------------------------------------------------
// Requests are inserts (tuser 0) or lookups (tuser 1), one at a time, each
// answered by exactly one response carrying a status and, on a hit, the
// stored value. The trie walks LEVEL_STRIDE key bits per level from the top
// of the key, at most ceil(64 / LEVEL_STRIDE) levels. Every level steps
// through index split, directory read, directory check, slot address, and
// slot read and update, set by the registered reads of the directory ram
// and the slot ram, which are read and written back in turn. A page that an
// insert touches for the first time is zeroed one slot per cycle; a collision
// pushdown adds a compare step per extra level plus index split, directory
// read, directory check, slot address and write for every slot it writes.
// With the defaults a lookup walks at most four levels. After reset the unit
// sweeps the page directory once, clearing all NODE_POOL * pages-per-node
// entries (16384 with the defaults), before it takes its first request. An
// insert that runs out of nodes or pages answers out of memory and keeps the
// writes done so far.
// ----------------------------------------------------------------------------
module paged_radix_trie_key_value_store_unit #(
  parameter int unsigned NODE_POOL     = prt_pkg::NodePoolDefault,
  parameter int unsigned PAGE_POOL     = prt_pkg::PagePoolDefault,
  parameter int unsigned SLOTS_IN_PAGE = prt_pkg::SlotsInPageDefault,
  parameter int unsigned LEVEL_STRIDE  = prt_pkg::LevelStrideDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request channel
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // key [63:0], value [127:64]
  input  logic         s_axis_tuser_i,   // opcode
  // response channel
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o    // status [2:0], value_out [65:3], zero pad
);

  import prt_pkg::*;

  // derived sizing
  localparam int unsigned NodeSlots = 1 << LEVEL_STRIDE;
  localparam int unsigned Ppn       = (NodeSlots + SLOTS_IN_PAGE - 1) / SLOTS_IN_PAGE;
  localparam int unsigned MaxDepth  = (64 + LEVEL_STRIDE - 1) / LEVEL_STRIDE;
  localparam int unsigned DirDepth  = NODE_POOL * Ppn;
  localparam int unsigned SlotDepth = PAGE_POOL * SLOTS_IN_PAGE;
  localparam int unsigned DAW  = (DirDepth > 1) ? $clog2(DirDepth) : 1;
  localparam int unsigned SAW  = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int unsigned NW   = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int unsigned NUW  = $clog2(NODE_POOL + 1);
  localparam int unsigned PW   = (PAGE_POOL > 1) ? $clog2(PAGE_POOL) : 1;
  localparam int unsigned PUW  = $clog2(PAGE_POOL + 1);
  localparam int unsigned PGW  = (Ppn > 1) ? $clog2(Ppn) : 1;
  localparam int unsigned OFW  = $clog2(SLOTS_IN_PAGE);
  localparam int unsigned DW   = $clog2(MaxDepth + 1);
  localparam int unsigned DirW = PW + 1;
  // page split of a level index by reciprocal multiplication, exact for
  // every index below 2^LEVEL_STRIDE
  localparam int unsigned RecipK = LEVEL_STRIDE + 13;
  localparam longint unsigned RecipM =
    ((64'd1 << RecipK) + SLOTS_IN_PAGE - 1) / SLOTS_IN_PAGE;
  localparam int unsigned PrW = LEVEL_STRIDE + RecipK + 1;

  // pushdown phases
  localparam logic [1:0] PhOld = 2'd0;  // write displaced leaf
  localparam logic [1:0] PhNew = 2'd1;  // write inserted leaf
  localparam logic [1:0] PhPtr = 2'd2;  // write pointer to an intermediate node

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_IDX   = 11'b000_0000_0100,
    S_DIR   = 11'b000_0000_1000,
    S_DIRW  = 11'b000_0001_0000,
    S_SADDR = 11'b000_0010_0000,
    S_ZERO  = 11'b000_0100_0000,
    S_SEVAL = 11'b000_1000_0000,
    S_PCMP  = 11'b001_0000_0000,
    S_PWR   = 11'b010_0000_0000,
    S_RESP  = 11'b100_0000_0000
  } state_e;

  // level index of a key at a given depth; the last level may overlap
  function automatic logic [LEVEL_STRIDE-1:0] level_index(input logic [63:0] k,
                                                          input logic [DW-1:0] d);
    logic [LEVEL_STRIDE-1:0] r;
    r = '0;
    for (int dd = 0; dd < MaxDepth; dd++) begin
      if (d == DW'(dd)) begin
        if (64 - (dd + 1) * int'(LEVEL_STRIDE) > 0) begin
          r = LEVEL_STRIDE'(k >> (64 - (dd + 1) * int'(LEVEL_STRIDE)));
        end else begin
          r = LEVEL_STRIDE'(k);
        end
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic              op_q;
  logic [63:0]       key_q, val_q, ek_q, ev_q;
  logic [DW-1:0]     depth_q;
  logic [NW-1:0]     node_q, mid_q;
  logic              push_q, fresh_q;
  logic [1:0]        ph_q;
  logic [LEVEL_STRIDE-1:0] idx_q;
  logic [PGW-1:0]    pg_q;
  logic [OFW-1:0]    off_q, zcnt_q;
  logic [PW-1:0]     page_q;
  logic [SAW-1:0]    sa_q, base_q;
  logic [DAW-1:0]    clr_q;
  logic [NUW-1:0]    nodes_used_q;
  logic [PUW-1:0]    pages_used_q;
  logic [2:0]        res_st_q;
  logic [62:0]       res_val_q;
  logic              m_valid_q;
  logic [2:0]        m_st_q;
  logic [62:0]       m_val_q;

  // memory ports
  logic            dir_we;
  logic [DAW-1:0]  dir_waddr, dir_addr_c;
  logic [DirW-1:0] dir_wdata, dir_rdata;
  logic            slot_we;
  logic [SAW-1:0]  slot_waddr, sa_c;
  slot_t           slot_wdata, slot_rdata, slot_cur;

  logic [63:0]              cur_key;
  logic [LEVEL_STRIDE-1:0]  idx_c, ie_c, in_c;
  logic [PrW-1:0]           prod_c;
  logic                     node_full, page_full, last_lvl;
  logic [62:0]              nxt;

  assign cur_key    = (push_q && ph_q != PhNew) ? ek_q : key_q;
  assign idx_c      = level_index(cur_key, depth_q);
  assign prod_c     = PrW'(idx_c) * PrW'(RecipM);
  assign dir_addr_c = DAW'(node_q) * DAW'(Ppn) + DAW'(pg_q);
  assign sa_c       = SAW'(page_q) * SAW'(SLOTS_IN_PAGE) + SAW'(off_q);
  assign slot_cur   = fresh_q ? '0 : slot_rdata;
  assign nxt        = slot_cur.val[62:0];
  assign node_full  = nodes_used_q >= NUW'(NODE_POOL);
  assign page_full  = pages_used_q >= PUW'(PAGE_POOL);
  assign last_lvl   = depth_q == DW'(MaxDepth - 1);
  assign ie_c       = level_index(ek_q, depth_q);
  assign in_c       = level_index(key_q, depth_q);

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, m_val_q, m_st_q};

  prt_ram #(.Width(DirW), .Depth(DirDepth)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_addr_c),
    .rdata_o (dir_rdata)
  );

  prt_ram #(.Width($bits(slot_t)), .Depth(SlotDepth)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (sa_c),
    .rdata_o (slot_rdata)
  );

  // memory write ports
  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = dir_addr_c;
    dir_wdata  = {1'b1, PW'(pages_used_q)};
    slot_we    = 1'b0;
    slot_waddr = sa_q;
    slot_wdata = '0;
    case (state_q)
      S_CLR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_q;
        dir_wdata = '0;
      end
      S_DIRW: begin
        dir_we = op_q == OpInsert && !dir_rdata[DirW-1] && !page_full;
      end
      S_ZERO: begin
        slot_we    = 1'b1;
        slot_waddr = base_q + SAW'(zcnt_q);
      end
      S_SEVAL: begin
        if (op_q == OpInsert) begin
          if (slot_cur.key == '0 && slot_cur.val == '0) begin
            slot_we    = 1'b1;
            slot_wdata = {val_q, key_q};
          end else if (!slot_cur.val[63]) begin
            if (slot_cur.key == key_q || last_lvl) begin
              slot_we    = 1'b1;
              slot_wdata = {val_q, slot_cur.key};
            end else if (!node_full) begin
              // collision: slot becomes a pointer to a fresh child
              slot_we    = 1'b1;
              slot_wdata = {1'b1, 63'(nodes_used_q), 64'd0};
            end
          end
        end
      end
      S_PWR: begin
        slot_we = 1'b1;
        case (ph_q)
          PhOld:   slot_wdata = {ev_q, ek_q};
          PhNew:   slot_wdata = {val_q, key_q};
          default: slot_wdata = {1'b1, 63'(mid_q), 64'd0};
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == DAW'(DirDepth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (s_axis_tuser_i == OpInsert && s_axis_tdata_i[127]) ? S_RESP : S_IDX;
        end
      end
      S_IDX:   state_d = S_DIR;
      S_DIR:   state_d = S_DIRW;
      S_DIRW: begin
        if (dir_rdata[DirW-1]) state_d = S_SADDR;
        else if (op_q == OpLookup || page_full) state_d = S_RESP;
        else state_d = S_SADDR;
      end
      S_SADDR: begin
        if (fresh_q) state_d = S_ZERO;
        else if (push_q) state_d = S_PWR;
        else state_d = S_SEVAL;
      end
      S_ZERO: begin
        if (zcnt_q == OFW'(SLOTS_IN_PAGE - 1)) state_d = push_q ? S_PWR : S_SEVAL;
      end
      S_SEVAL: begin
        if (slot_cur.key == '0 && slot_cur.val == '0) state_d = S_RESP;
        else if (slot_cur.val[63]) begin
          state_d = (nxt >= 63'(nodes_used_q) || last_lvl) ? S_RESP : S_IDX;
        end else if (op_q == OpLookup || slot_cur.key == key_q || last_lvl || node_full) begin
          state_d = S_RESP;
        end else state_d = S_PCMP;
      end
      S_PCMP: begin
        if (depth_q == DW'(MaxDepth)) state_d = S_RESP;
        else if (ie_c != in_c) state_d = S_IDX;
        else state_d = node_full ? S_RESP : S_IDX;
      end
      S_PWR:   state_d = (ph_q == PhOld) ? S_IDX : ((ph_q == PhNew) ? S_RESP : S_PCMP);
      S_RESP:  if (!m_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      nodes_used_q <= NUW'(1);
      pages_used_q <= '0;
      m_valid_q    <= 1'b0;
      push_q       <= 1'b0;
      fresh_q      <= 1'b0;
      ph_q         <= PhOld;
      zcnt_q       <= '0;
      depth_q      <= '0;
    end else begin
      state_q <= state_d;
      // response register: loads in S_RESP, empties when taken
      if (state_q == S_RESP && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: clr_q <= clr_q + DAW'(1);
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            depth_q <= '0;
            push_q  <= 1'b0;
            ph_q    <= PhOld;
          end
        end
        S_DIRW: begin
          fresh_q <= !dir_rdata[DirW-1] && op_q == OpInsert && !page_full;
          if (!dir_rdata[DirW-1] && op_q == OpInsert && !page_full) begin
            pages_used_q <= pages_used_q + PUW'(1);
          end
        end
        S_ZERO: begin
          zcnt_q <= (zcnt_q == OFW'(SLOTS_IN_PAGE - 1)) ? '0 : zcnt_q + OFW'(1);
        end
        S_SEVAL: begin
          if (slot_cur.val[63] && !(slot_cur.key == '0 && slot_cur.val == '0)) begin
            depth_q <= depth_q + DW'(1);
          end else if (op_q == OpInsert && !(slot_cur.key == '0 && slot_cur.val == '0)
                       && slot_cur.key != key_q && !last_lvl && !node_full) begin
            nodes_used_q <= nodes_used_q + NUW'(1);
            depth_q      <= depth_q + DW'(1);
            push_q       <= 1'b1;
          end
        end
        S_PCMP: begin
          if (depth_q != DW'(MaxDepth)) begin
            if (ie_c != in_c) ph_q <= PhOld;
            else if (!node_full) begin
              ph_q         <= PhPtr;
              nodes_used_q <= nodes_used_q + NUW'(1);
            end
          end
        end
        S_PWR: begin
          if (ph_q == PhOld) ph_q <= PhNew;
          else if (ph_q == PhPtr) depth_q <= depth_q + DW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q      <= s_axis_tuser_i;
        key_q     <= s_axis_tdata_i[63:0];
        val_q     <= s_axis_tdata_i[127:64];
        node_q    <= '0;
        res_st_q  <= StReject;
        res_val_q <= '0;
      end
      S_IDX: begin
        idx_q <= idx_c;
        pg_q  <= PGW'(prod_c >> RecipK);
      end
      S_DIR: off_q <= OFW'(idx_q - LEVEL_STRIDE'(LEVEL_STRIDE'(pg_q) * LEVEL_STRIDE'(SLOTS_IN_PAGE)));
      S_DIRW: begin
        if (dir_rdata[DirW-1]) page_q <= dir_rdata[PW-1:0];
        else begin
          page_q   <= PW'(pages_used_q);
          res_st_q <= (op_q == OpLookup) ? StMiss : StOom;
        end
      end
      S_SADDR: begin
        sa_q   <= sa_c;
        base_q <= SAW'(page_q) * SAW'(SLOTS_IN_PAGE);
      end
      S_SEVAL: begin
        if (slot_cur.key == '0 && slot_cur.val == '0) begin
          res_st_q <= (op_q == OpLookup) ? StMiss : StNew;
        end else if (slot_cur.val[63]) begin
          node_q   <= NW'(nxt);
          res_st_q <= (op_q == OpLookup) ? StMiss : StOom;
        end else if (op_q == OpLookup) begin
          if (slot_cur.key == key_q) begin
            res_st_q  <= StFound;
            res_val_q <= slot_cur.val[62:0];
          end else res_st_q <= StMiss;
        end else if (slot_cur.key == key_q || last_lvl) begin
          res_st_q <= StUpdated;
        end else begin
          res_st_q <= StOom;
          ek_q     <= slot_cur.key;
          ev_q     <= slot_cur.val;
          node_q   <= NW'(nodes_used_q);
        end
      end
      S_PCMP: begin
        res_st_q <= StOom;
        mid_q    <= NW'(nodes_used_q);
      end
      S_PWR: begin
        if (ph_q == PhNew) res_st_q <= StNew;
        else if (ph_q == PhPtr) node_q <= mid_q;
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_st_q  <= res_st_q;
          m_val_q <= res_val_q;
        end
      end
      default: ;
    endcase
  end

endmodule
